// File: hw/rtl/uadac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uadac_pkg
// Shared types and constants for the address checker.
// ----------------------------------------------------------------------------
package uadac_pkg;

    localparam int LOCAL_LIMIT_DEFAULT  = 64;
    localparam int DOMAIN_LIMIT_DEFAULT = 253;
    localparam int LABEL_MAX            = 63;
    localparam int LABEL_W              = 6;

    localparam logic [7:0] CHAR_AT    = 8'h40;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_DASH  = 8'h2d;
    localparam logic [7:0] CHAR_UNDER = 8'h5f;
    localparam logic [7:0] CTRL_TOP   = 8'h20;
    localparam logic [7:0] CHAR_DEL   = 8'h7f;
    localparam logic [7:0] CASE_DELTA = 8'd32;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       address_valid;
    } out_item_t;

    typedef struct packed {
        logic is_ctrl;
        logic is_at;
        logic is_dot;
        logic is_dash;
        logic is_upper;
        logic local_ok;
        logic domain_ok;
    } byte_class_t;

endpackage

// File: hw/rtl/uadac_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uadac_classify
// Decodes one address byte into its character classes.
// ----------------------------------------------------------------------------
module uadac_classify
(
    input  logic [7:0]             data,
    output uadac_pkg::byte_class_t cls
);

    logic is_lower;
    logic is_upper;
    logic is_digit;
    logic is_alnum;

    always_comb
    begin
        is_lower = (data >= 8'h61) && (data <= 8'h7a);
        is_upper = (data >= 8'h41) && (data <= 8'h5a);
        is_digit = (data >= 8'h30) && (data <= 8'h39);
        is_alnum = is_lower || is_upper || is_digit;

        cls.is_ctrl   = (data <= uadac_pkg::CTRL_TOP) || (data == uadac_pkg::CHAR_DEL);
        cls.is_at     = (data == uadac_pkg::CHAR_AT);
        cls.is_dot    = (data == uadac_pkg::CHAR_DOT);
        cls.is_dash   = (data == uadac_pkg::CHAR_DASH);
        cls.is_upper  = is_upper;
        cls.domain_ok = is_alnum || cls.is_dash || (data == uadac_pkg::CHAR_UNDER);
        cls.local_ok  = cls.domain_ok || cls.is_dot;
    end

endmodule

// File: hw/rtl/uadac_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uadac_scan
// Per-address scan state, echo byte and verdict for the current item.
// ----------------------------------------------------------------------------
module uadac_scan
#(
    parameter int LOCAL_LIMIT  = uadac_pkg::LOCAL_LIMIT_DEFAULT,
    parameter int DOMAIN_LIMIT = uadac_pkg::DOMAIN_LIMIT_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  uadac_pkg::in_item_t  item,
    output uadac_pkg::out_item_t result
);

    localparam int LCW = $clog2(LOCAL_LIMIT + 1);
    localparam int DCW = $clog2(DOMAIN_LIMIT + 1);
    localparam logic [LCW-1:0] LOCAL_LIM  = LCW'(LOCAL_LIMIT);
    localparam logic [DCW-1:0] DOMAIN_LIM = DCW'(DOMAIN_LIMIT);
    localparam logic [uadac_pkg::LABEL_W-1:0] LABEL_LIM =
        uadac_pkg::LABEL_W'(uadac_pkg::LABEL_MAX);

    uadac_pkg::byte_class_t cls;

    logic                          in_domain_part_reg, in_domain_part_next;
    logic [LCW-1:0]                local_count_reg, local_count_next;
    logic [DCW-1:0]                domain_count_reg, domain_count_next;
    logic [uadac_pkg::LABEL_W-1:0] label_count_reg, label_count_next;
    logic                          saw_domain_dot_reg, saw_domain_dot_next;
    logic                          prev_was_dot_reg, prev_was_dot_next;
    logic                          failed_reg, failed_next;

    logic [7:0] echo;
    logic       verdict;

    uadac_classify u_classify
    (
        .data (item.in_byte),
        .cls  (cls)
    );

    always_comb
    begin
        in_domain_part_next = in_domain_part_reg;
        local_count_next    = local_count_reg;
        domain_count_next   = domain_count_reg;
        label_count_next    = label_count_reg;
        saw_domain_dot_next = saw_domain_dot_reg;
        prev_was_dot_next   = prev_was_dot_reg;
        failed_next         = failed_reg | cls.is_ctrl;
        echo                = item.in_byte;

        if (!in_domain_part_reg)
        begin
            if (cls.is_at)
            begin
                if ((local_count_reg == '0) || prev_was_dot_reg)
                begin
                    failed_next = 1'b1;
                end
                in_domain_part_next = 1'b1;
                label_count_next    = '0;
            end
            else
            begin
                if (!cls.local_ok || (cls.is_dot && (local_count_reg == '0)))
                begin
                    failed_next = 1'b1;
                end
                if (local_count_reg >= LOCAL_LIM)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    local_count_next = local_count_reg + LCW'(1);
                end
                prev_was_dot_next = cls.is_dot;
            end
        end
        else
        begin
            if (cls.is_upper)
            begin
                echo = item.in_byte + uadac_pkg::CASE_DELTA;
            end
            if (domain_count_reg >= DOMAIN_LIM)
            begin
                failed_next = 1'b1;
            end
            else
            begin
                domain_count_next = domain_count_reg + DCW'(1);
            end
            if (cls.is_dot)
            begin
                if (label_count_reg == '0)
                begin
                    failed_next = 1'b1;
                end
                label_count_next    = '0;
                saw_domain_dot_next = 1'b1;
            end
            else
            begin
                if (!cls.domain_ok || ((label_count_reg == '0) && cls.is_dash))
                begin
                    failed_next = 1'b1;
                end
                if (label_count_reg >= LABEL_LIM)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    label_count_next = label_count_reg + uadac_pkg::LABEL_W'(1);
                end
            end
        end

        verdict = item.in_last && !failed_next && in_domain_part_next &&
                  (domain_count_next != '0) && (label_count_next != '0) &&
                  saw_domain_dot_next;

        // drop all state at the end of an address
        if (item.in_last)
        begin
            in_domain_part_next = 1'b0;
            local_count_next    = '0;
            domain_count_next   = '0;
            label_count_next    = '0;
            saw_domain_dot_next = 1'b0;
            prev_was_dot_next   = 1'b0;
            failed_next         = 1'b0;
        end

        result.out_byte      = echo;
        result.out_last      = item.in_last;
        result.address_valid = verdict;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_domain_part_reg <= 1'b0;
            local_count_reg    <= '0;
            domain_count_reg   <= '0;
            label_count_reg    <= '0;
            saw_domain_dot_reg <= 1'b0;
            prev_was_dot_reg   <= 1'b0;
            failed_reg         <= 1'b0;
        end
        else if (advance)
        begin
            in_domain_part_reg <= in_domain_part_next;
            local_count_reg    <= local_count_next;
            domain_count_reg   <= domain_count_next;
            label_count_reg    <= label_count_next;
            saw_domain_dot_reg <= saw_domain_dot_next;
            prev_was_dot_reg   <= prev_was_dot_next;
            failed_reg         <= failed_next;
        end
    end

endmodule

// File: hw/rtl/user_at_domain_address_checker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// user_at_domain_address_checker_unit
// Streams a name@domain address one byte per item, echoes each byte
// (lower-cased after the '@') and gives the verdict on the last byte.
//
// Channels: src_valid/src_stall/src_item take input items (byte, last mark);
// dst_valid/dst_stall/dst_item deliver one result item per input item.
// An item moves when valid is high and stall is low at a rising edge.
// An accepted item passes through the input register and then the result
// register before dst_valid rises for it. Throughput: one item per cycle
// while dst_stall is low; the scan state is a handful of small counters and
// flags updated once per byte. Reset clears both pipeline valid flags and
// the scan state; the block then expects the first byte of a new address.
// The last-marked byte also returns the scan state to its reset value.
// While the receiver stalls, the result register holds, the input register
// fills and then src_stall rises.
// ----------------------------------------------------------------------------
module user_at_domain_address_checker_unit
#(
    parameter int LOCAL_LIMIT  = uadac_pkg::LOCAL_LIMIT_DEFAULT,
    parameter int DOMAIN_LIMIT = uadac_pkg::DOMAIN_LIMIT_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  uadac_pkg::in_item_t  src_item,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output uadac_pkg::out_item_t dst_item
);

    logic                 hold_valid_reg;
    uadac_pkg::in_item_t  hold_item_reg;
    logic                 res_valid_reg;
    uadac_pkg::out_item_t res_item_reg;
    uadac_pkg::out_item_t scan_result;
    logic                 res_open;
    logic                 advance;
    logic                 src_take;

    assign res_open  = !res_valid_reg || !dst_stall;
    assign advance   = hold_valid_reg && res_open;
    assign src_stall = hold_valid_reg && !res_open;
    assign src_take  = src_valid && !src_stall;

    uadac_scan
    #(
        .LOCAL_LIMIT  (LOCAL_LIMIT),
        .DOMAIN_LIMIT (DOMAIN_LIMIT)
    )
    u_scan
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (hold_item_reg),
        .result  (scan_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (src_take)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (res_open)
            begin
                res_valid_reg <= advance;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_take)
        begin
            hold_item_reg <= src_item;
        end
        if (advance)
        begin
            res_item_reg <= scan_result;
        end
    end

    assign dst_valid = res_valid_reg;
    assign dst_item  = res_item_reg;

endmodule
